// ===== rtl/sclp_pkg.sv =====
`timescale 1ns / 1ps

package sclp_pkg;

    localparam int CMD_COUNT = 40;
    localparam int CODE_W    = 6;
    localparam int TLEN_W    = 4;
    localparam int DATA_W    = 104;

    localparam logic [CODE_W-1:0] NO_MATCH = CODE_W'(CMD_COUNT);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Letter pairs, first letter in the upper byte.
    localparam logic [15:0] CMD_TABLE [CMD_COUNT] = '{
        "XY",
        "GM", "GZ", "GY", "GA", "GI", "GJ", "GF", "GG", "GD", "GE",
        "HG", "HK", "HM", "HL", "HO", "HH", "HX", "HY", "HD", "HC", "HZ", "HW", "HR",
        "JG", "JK", "JM", "JL", "JO", "JH", "JX", "JY", "JD", "JC", "JZ", "JW", "JR",
        "SC", "SD",
        "DU"
    };

    typedef enum logic [2:0] {
        PS_FIRST  = 3'd0,
        PS_SECOND = 3'd1,
        PS_NUM1   = 3'd2,
        PS_NUM2   = 3'd3,
        PS_TEXT   = 3'd4
    } parse_state_t;

    // Command fields shared by every result of one command line.
    typedef struct packed {
        logic              save;
        logic              quit;
        logic              request;
        logic [31:0]       number2;
        logic [31:0]       number;
        logic [7:0]        second;
        logic [7:0]        first;
        logic [CODE_W-1:0] code;
    } cmd_rec_t;

    function automatic logic [CODE_W-1:0] cmd_lookup(input logic [7:0] a,
                                                     input logic [7:0] b);
        logic [CODE_W-1:0] code;
        code = NO_MATCH;
        // Scan downward so that the first matching entry wins.
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
            if (CMD_TABLE[i] == {a, b})
            begin
                code = CODE_W'(i);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/serial_command_line_parser.sv =====
`timescale 1ns / 1ps

// A terminator beat is registered into the emitter's record; its command result then leaves
// through the output register, and text results follow at one per cycle from the text memory
// (registered read) while the receiver keeps taking them. Throughput: one input beat per cycle;
// a terminator beat waits while the previous command still has results in the emitter.
// Reset: rst_n asynchronous, active low; parser returns to awaiting the first letter, numbers
// and counts clear, the text memory is not cleared.
module serial_command_line_parser #(
    parameter int TEXT_DEPTH = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // char_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // command_code, first_letter, second_letter, number_value, second_number,
    // request_flag, quit_flag, save_flag, text_length, text_byte, zero fill
    output logic [sclp_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tuser,   // result_kind
    output logic                        m_tlast    // last_of_run
);
    import sclp_pkg::*;

    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam int AW = $clog2(2 * TEXT_DEPTH);
    localparam int PAD_W = DATA_W - $bits(cmd_rec_t) - TLEN_W - 8;

    function automatic logic [AW-1:0] mem_addr(input logic bank, input logic [CW-1:0] idx);
        logic [AW-1:0] base;
        base = bank ? AW'(TEXT_DEPTH) : '0;
        return base + AW'(idx);
    endfunction

    // Parser state.
    parse_state_t      parse_state_reg, parse_state_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [31:0]       num_reg, num_next;
    logic [31:0]       num2_reg, num2_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CW-1:0]     tcount_reg, tcount_next;
    logic              wbank_reg, wbank_next;

    // Emitter state.
    cmd_rec_t          rec_reg, rec_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              rbank_reg, rbank_next;
    logic              em_active_reg, em_active_next;
    logic              em_hdr_reg, em_hdr_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     sent_reg, sent_next;
    logic              rd_valid_reg, rd_valid_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    cmd_rec_t          out_rec_reg, out_rec_next;
    logic [TLEN_W-1:0] out_tlen_reg, out_tlen_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    // Text memory, two banks so one line is captured while the last one is read out.
    logic [7:0]        mem [2 * TEXT_DEPTH];
    logic [7:0]        mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic [7:0]        ch;
    logic [7:0]        ch_up;
    logic              is_letter;
    logic              is_digit;
    logic              term_num;
    logic              term_text;
    logic              finish_hit;
    logic              accept;
    logic              out_free;
    logic              hdr_go;
    logic              consume;
    logic              issue;
    logic              text_last;
    logic [31:0]       acc_src;
    logic [31:0]       acc_mul;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= ch;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg <= PS_FIRST;
            first_reg       <= '0;
            second_reg      <= '0;
            num_reg         <= '0;
            num2_reg        <= '0;
            code_reg        <= NO_MATCH;
            tcount_reg      <= '0;
            wbank_reg       <= 1'b0;
            n_reg           <= '0;
            rbank_reg       <= 1'b0;
            em_active_reg   <= 1'b0;
            em_hdr_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            sent_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            parse_state_reg <= parse_state_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            num_reg         <= num_next;
            num2_reg        <= num2_next;
            code_reg        <= code_next;
            tcount_reg      <= tcount_next;
            wbank_reg       <= wbank_next;
            n_reg           <= n_next;
            rbank_reg       <= rbank_next;
            em_active_reg   <= em_active_next;
            em_hdr_reg      <= em_hdr_next;
            rd_idx_reg      <= rd_idx_next;
            sent_reg        <= sent_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg      <= rec_next;
        out_rec_reg  <= out_rec_next;
        out_tlen_reg <= out_tlen_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        ch        = s_tdata;
        is_letter = (ch >= CH_UA && ch <= CH_UZ) || (ch >= CH_LA && ch <= CH_LZ) ||
                    (ch == CH_QUERY);
        ch_up     = (ch >= CH_LA && ch <= CH_LZ) ? ch - CASE_OFS : ch;
        is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        term_num  = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_SEMI) ||
                    (ch == CH_QUERY) || (ch == CH_BANG) || (ch == CH_DOLL);
        term_text = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_SEMI) ||
                    (ch == CH_QUERY) || (ch == CH_BANG) || (ch == CH_PCT);
        finish_hit = ((parse_state_reg == PS_NUM1 || parse_state_reg == PS_NUM2) && term_num) ||
                     ((parse_state_reg == PS_TEXT) && term_text);

        // A terminator needs the emitter's record, so it waits until that is free.
        s_tready = !(finish_hit && em_active_reg);
        accept   = s_tvalid && s_tready;

        acc_src = (parse_state_reg == PS_NUM1) ? num_reg : num2_reg;
        acc_mul = (acc_src << 3) + (acc_src << 1) + 32'(ch - CH_ZERO);

        parse_state_next = parse_state_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        num_next         = num_reg;
        num2_next        = num2_reg;
        code_next        = code_reg;
        tcount_next      = tcount_reg;
        wbank_next       = wbank_reg;
        rec_next         = rec_reg;
        n_next           = n_reg;
        rbank_next       = rbank_reg;
        em_active_next   = em_active_reg;
        em_hdr_next      = em_hdr_reg;
        rd_idx_next      = rd_idx_reg;
        sent_next        = sent_reg;
        rd_valid_next    = rd_valid_reg;
        out_valid_next   = out_valid_reg;
        out_rec_next     = out_rec_reg;
        out_tlen_next    = out_tlen_reg;
        out_byte_next    = out_byte_reg;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = mem_addr(wbank_reg, tcount_reg);

        // Emitter: header first, then one text byte per cycle from the memory while the output is free.
        out_free  = !out_valid_reg || m_tready;
        hdr_go    = em_active_reg && em_hdr_reg && out_free;
        consume   = em_active_reg && !em_hdr_reg && rd_valid_reg && out_free;
        issue     = em_active_reg && (rd_idx_reg < n_reg) && (!rd_valid_reg || consume);
        text_last = (sent_reg + CW'(1)) == n_reg;
        mem_re    = issue;
        mem_raddr = mem_addr(rbank_reg, rd_idx_reg);

        if (issue)
        begin
            rd_valid_next = 1'b1;
            rd_idx_next   = rd_idx_reg + CW'(1);
        end
        else if (consume)
        begin
            rd_valid_next = 1'b0;
        end

        if (hdr_go)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = rec_reg;
            out_tlen_next  = TLEN_W'(n_reg);
            out_byte_next  = '0;
            out_kind_next  = 1'b0;
            out_last_next  = (n_reg == '0);
            em_hdr_next    = 1'b0;
            if (n_reg == '0)
            begin
                em_active_next = 1'b0;
            end
        end
        else if (consume)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = rec_reg;
            out_tlen_next  = TLEN_W'(n_reg);
            out_byte_next  = mem_q;
            out_kind_next  = 1'b1;
            out_last_next  = text_last;
            sent_next      = sent_reg + CW'(1);
            if (text_last)
            begin
                em_active_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Parser: one beat per cycle, except that a terminator is held while the emitter is busy.
        if (accept)
        begin
            case (parse_state_reg)
                PS_FIRST:
                begin
                    if (is_letter)
                    begin
                        first_next       = ch_up;
                        parse_state_next = PS_SECOND;
                    end
                end
                PS_SECOND:
                begin
                    if (is_letter)
                    begin
                        second_next      = ch_up;
                        // Both letters are fixed from here on, so the lookup is done now.
                        code_next        = cmd_lookup(first_reg, ch_up);
                        num_next         = '0;
                        tcount_next      = '0;
                        parse_state_next = PS_NUM1;
                    end
                end
                PS_NUM1, PS_NUM2:
                begin
                    if (is_digit)
                    begin
                        if (parse_state_reg == PS_NUM1)
                        begin
                            num_next = acc_mul;
                        end
                        else
                        begin
                            num2_next = acc_mul;
                        end
                    end
                    else if (ch == CH_COMMA)
                    begin
                        if (parse_state_reg == PS_NUM1)
                        begin
                            num2_next        = '0;
                            parse_state_next = PS_NUM2;
                        end
                    end
                    else if (ch == CH_QUOTE)
                    begin
                        tcount_next      = '0;
                        parse_state_next = PS_TEXT;
                    end
                end
                PS_TEXT:
                begin
                    if (ch != CH_QUOTE && !term_text && tcount_reg < CW'(TEXT_DEPTH))
                    begin
                        mem_we      = 1'b1;
                        tcount_next = tcount_reg + CW'(1);
                    end
                end
                default:
                begin
                    parse_state_next = PS_FIRST;
                end
            endcase

            if (finish_hit)
            begin
                parse_state_next = PS_FIRST;
                rec_next.code    = code_reg;
                rec_next.first   = first_reg;
                rec_next.second  = second_reg;
                rec_next.number  = num_reg;
                rec_next.number2 = num2_reg;
                rec_next.request = (ch == CH_QUERY);
                rec_next.quit    = (ch == CH_BANG);
                rec_next.save    = (parse_state_reg == PS_TEXT) ? (ch == CH_PCT)
                                                                : (ch == CH_DOLL);
                n_next           = tcount_reg;
                rbank_next       = wbank_reg;
                wbank_next       = !wbank_reg;
                em_active_next   = 1'b1;
                em_hdr_next      = 1'b1;
                rd_idx_next      = '0;
                sent_next        = '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_byte_reg, out_tlen_reg, out_rec_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/sv/tb_serial_command_line_parser.sv =====
`timescale 1ns / 1ps

module tb_serial_command_line_parser;

    import sclp_pkg::*;

    localparam int TEXT_DEPTH  = 10;
    localparam int RANDOM_BYTES = 95;
    localparam int HOLD_AT     = 16;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] CHR_LF     = 8'd10;
    localparam logic [7:0] CHR_CR     = 8'd13;
    localparam logic [7:0] CHR_QUOTE  = 8'd34;
    localparam logic [7:0] CHR_BANG   = 8'h21;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_PCT    = 8'h25;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_QMARK  = 8'h3F;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_UA     = 8'h41;
    localparam logic [7:0] CHR_UZ     = 8'h5A;
    localparam logic [7:0] CHR_LA     = 8'h61;
    localparam logic [7:0] CHR_LZ     = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [7:0] NUM_ENDS [6]  = '{CHR_LF, CHR_CR, CHR_SEMI, CHR_QMARK, CHR_BANG,
                                             CHR_DOLLAR};
    localparam logic [7:0] TEXT_ENDS [6] = '{CHR_LF, CHR_CR, CHR_SEMI, CHR_QMARK, CHR_BANG,
                                             CHR_PCT};

    localparam logic [15:0] CMD_PAIRS [40] = '{
        "XY",
        "GM", "GZ", "GY", "GA", "GI", "GJ", "GF", "GG", "GD", "GE",
        "HG", "HK", "HM", "HL", "HO", "HH", "HX", "HY", "HD", "HC", "HZ", "HW", "HR",
        "JG", "JK", "JM", "JL", "JO", "JH", "JX", "JY", "JD", "JC", "JZ", "JW", "JR",
        "SC", "SD",
        "DU"
    };

    // Noise before the first letter and between the letters, numbers with a doubled
    // comma and a stray percent sign, text with a dropped quote and a literal dollar,
    // and a pair that matches nothing.
    localparam logic [7:0] OPENING [28] = '{
        8'hFF, "s", 8'h00, "d", "7", CHR_COMMA, CHR_COMMA, "3", CHR_PCT, "x", CHR_QMARK,
        "g", "m", CHR_QUOTE, "a", CHR_DOLLAR, CHR_QUOTE, "b", CHR_PCT,
        "h", "r", CHR_BANG,
        "x", "Y", CHR_LF,
        CHR_QMARK, CHR_QMARK, CHR_CR
    };

    typedef struct {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [7:0]        first_letter;
        logic [7:0]        second_letter;
        logic [31:0]       number;
        logic [31:0]       number2;
        logic              request;
        logic              quit;
        logic              save;
        logic [TLEN_W-1:0] text_len;
        logic [7:0]        text_char;
        logic              last;
    } parser_result_t;

    typedef struct packed {
        logic [2:0]        fill;
        logic [7:0]        text_char;
        logic [TLEN_W-1:0] text_len;
        logic              save;
        logic              quit;
        logic              request;
        logic [31:0]       number2;
        logic [31:0]       number;
        logic [7:0]        second_letter;
        logic [7:0]        first_letter;
        logic [CODE_W-1:0] code;
    } result_word_t;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } serial_byte_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    serial_byte_t        line_bytes [$];
    parser_result_t      line_results_due [$];
    bit                  drain_next = 1'b0;

    // Shadow of the parser state.
    parse_state_t        pstate = PS_FIRST;
    logic [7:0]          held_first = '0;
    logic [7:0]          held_second = '0;
    logic [31:0]         acc_first = '0;
    logic [31:0]         acc_second = '0;
    logic [7:0]          captured [TEXT_DEPTH];
    int                  captured_n = 0;

    int                  failures = 0;
    int                  results_seen = 0;
    int                  send_gap = 0;
    bit                  send_burst = 1'b0;
    int                  take_stall = 0;
    bit                  take_burst = 1'b0;
    int                  cycle_count = 0;

    serial_command_line_parser #(
        .TEXT_DEPTH(TEXT_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit is_cmd_letter(input logic [7:0] c);
        return (c >= CHR_UA && c <= CHR_UZ) || (c >= CHR_LA && c <= CHR_LZ) || c == CHR_QMARK;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= CHR_LA && c <= CHR_LZ) ? c - CASE_BIT : c;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHR_ZERO && c <= CHR_NINE;
    endfunction

    function automatic bit is_num_end(input logic [7:0] c);
        return c == CHR_LF || c == CHR_CR || c == CHR_SEMI || c == CHR_QMARK ||
               c == CHR_BANG || c == CHR_DOLLAR;
    endfunction

    function automatic bit is_text_end(input logic [7:0] c);
        return c == CHR_LF || c == CHR_CR || c == CHR_SEMI || c == CHR_QMARK ||
               c == CHR_BANG || c == CHR_PCT;
    endfunction

    function automatic logic [CODE_W-1:0] pair_code(input logic [7:0] a, input logic [7:0] b);
        for (int i = 0; i < CMD_COUNT; i++)
        begin
            if (CMD_PAIRS[i] == {a, b})
            begin
                return CODE_W'(i);
            end
        end
        return NO_MATCH;
    endfunction

    // Queue the command result and one result per captured text byte.
    task automatic close_line(input logic [7:0] c, input logic [7:0] save_ch);
        parser_result_t r;
        r.kind          = 1'b0;
        r.code          = pair_code(held_first, held_second);
        r.first_letter  = held_first;
        r.second_letter = held_second;
        r.number        = acc_first;
        r.number2       = acc_second;
        r.request       = (c == CHR_QMARK);
        r.quit          = (c == CHR_BANG);
        r.save          = (c == save_ch);
        r.text_len      = TLEN_W'(captured_n);
        r.text_char     = '0;
        r.last          = (captured_n == 0);
        line_results_due.push_back(r);
        for (int k = 0; k < captured_n; k++)
        begin
            r.kind      = 1'b1;
            r.text_char = captured[k];
            r.last      = (k == captured_n - 1);
            line_results_due.push_back(r);
        end
        pstate = PS_FIRST;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        case (pstate)
            PS_FIRST:
            begin
                if (is_cmd_letter(c))
                begin
                    held_first = to_upper(c);
                    pstate = PS_SECOND;
                end
            end
            PS_SECOND:
            begin
                if (is_cmd_letter(c))
                begin
                    held_second = to_upper(c);
                    acc_first = '0;
                    captured_n = 0;
                    pstate = PS_NUM1;
                end
            end
            PS_NUM1, PS_NUM2:
            begin
                if (is_digit(c))
                begin
                    if (pstate == PS_NUM1)
                        acc_first = acc_first * 32'd10 + 32'(c - CHR_ZERO);
                    else
                        acc_second = acc_second * 32'd10 + 32'(c - CHR_ZERO);
                end
                else if (c == CHR_COMMA)
                begin
                    if (pstate == PS_NUM1)
                    begin
                        acc_second = '0;
                        pstate = PS_NUM2;
                    end
                end
                else if (c == CHR_QUOTE)
                begin
                    captured_n = 0;
                    pstate = PS_TEXT;
                end
                else if (is_num_end(c))
                begin
                    close_line(c, CHR_DOLLAR);
                end
            end
            PS_TEXT:
            begin
                if (c != CHR_QUOTE)
                begin
                    if (is_text_end(c))
                        close_line(c, CHR_PCT);
                    else if (captured_n < TEXT_DEPTH)
                    begin
                        captured[captured_n] = c;
                        captured_n++;
                    end
                end
            end
            default:
            begin
                pstate = PS_FIRST;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] c);
        serial_byte_t b;
        b.ch = c;
        b.drain = drain_next;
        drain_next = 1'b0;
        line_bytes.push_back(b);
    endtask

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CHR_UA + 8'(r);
        else if (r < 52)
            return CHR_LA + 8'(r - 26);
        return CHR_QMARK;
    endfunction

    function automatic logic [7:0] idle_noise();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_cmd_letter(c));
        return c;
    endfunction

    function automatic logic [7:0] number_noise();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return CHR_PCT;
        do c = 8'($urandom_range(0, 255));
        while (is_digit(c) || c == CHR_COMMA || c == CHR_QUOTE || is_num_end(c));
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_text_end(c) || c == CHR_QUOTE);
        return c;
    endfunction

    // Long runs of digits make the accumulators wrap.
    task automatic add_digits();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            push_byte(CHR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // A broken line stops after its first letter or after its numbers.
    task automatic add_line(input bit broken);
        logic [15:0] pair;
        logic [7:0]  a;
        logic [7:0]  b;
        bit          in_text;
        int          n;
        if ($urandom_range(0, 5) == 0)
            push_byte(idle_noise());
        if ($urandom_range(0, 4) == 0)
        begin
            a = any_letter();
            b = any_letter();
        end
        else
        begin
            pair = CMD_PAIRS[$urandom_range(0, 39)];
            a = pair[15:8] | ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
            b = pair[7:0] | ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
        end
        push_byte(a);
        if (broken && $urandom_range(0, 1))
            return;
        if ($urandom_range(0, 7) == 0)
            push_byte(idle_noise());
        push_byte(b);
        if ($urandom_range(0, 3) == 0)
            push_byte(number_noise());
        if ($urandom_range(0, 3) != 0)
            add_digits();
        if ($urandom_range(0, 2) == 0)
        begin
            push_byte(CHR_COMMA);
            if ($urandom_range(0, 3) == 0)
                push_byte(CHR_COMMA);
            if ($urandom_range(0, 3) != 0)
                add_digits();
        end
        if (broken)
            return;
        in_text = ($urandom_range(0, 2) == 0);
        if (in_text)
        begin
            push_byte(CHR_QUOTE);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 11))
                    0: push_byte(CHR_QUOTE);
                    1: push_byte(CHR_DOLLAR);
                    default: push_byte(text_char());
                endcase
            end
            push_byte(TEXT_ENDS[$urandom_range(0, 5)]);
        end
        else
        begin
            push_byte(NUM_ENDS[$urandom_range(0, 5)]);
        end
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        result_word_t   w;
        parser_result_t want;
        w = m_tdata;
        if (line_results_due.size() == 0)
        begin
            $error("result beat with nothing expected: tdata %h", m_tdata);
            failures++;
            return;
        end
        want = line_results_due.pop_front();
        match_field("result_kind", 32'(want.kind), 32'(m_tuser));
        match_field("command_code", 32'(want.code), 32'(w.code));
        match_field("first_letter", 32'(want.first_letter), 32'(w.first_letter));
        match_field("second_letter", 32'(want.second_letter), 32'(w.second_letter));
        match_field("number_value", want.number, w.number);
        match_field("second_number", want.number2, w.number2);
        match_field("request_flag", 32'(want.request), 32'(w.request));
        match_field("quit_flag", 32'(want.quit), 32'(w.quit));
        match_field("save_flag", 32'(want.save), 32'(w.save));
        match_field("text_length", 32'(want.text_len), 32'(w.text_len));
        match_field("text_byte", 32'(want.text_char), 32'(w.text_char));
        match_field("last_of_run", 32'(want.last), 32'(m_tlast));
        match_field("tdata_fill", 32'd0, 32'(w.fill));
    endtask

    // Sender: a byte is taken at an edge with tvalid and tready both high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 11);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (line_bytes.size() > 0 &&
                         !(line_bytes[0].drain && line_results_due.size() > 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= line_bytes[0].ch;
                    void'(line_bytes.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off lets the parser back up onto its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
                results_seen++;
                if ($urandom_range(0, 15) == 0)
                    take_burst = !take_burst;
                take_stall = take_burst ? 0 : $urandom_range(0, 11);
                if (results_seen == HOLD_AT)
                    take_stall = LONG_HOLD;
            end
            if (take_stall > 0)
            begin
                take_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_serial_command_line_parser failed");
            $finish;
        end
    end

    initial
    begin
        foreach (OPENING[i])
            push_byte(OPENING[i]);
        // The first random line waits until the directed lines have fully drained.
        drain_next = 1'b1;
        while (line_bytes.size() < $size(OPENING) + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                drain_next = 1'b1;
            add_line($urandom_range(0, 7) == 0);
        end
        // Close whatever line is open, then one clean line.
        push_byte(CHR_LF);
        push_byte("X");
        push_byte("Y");
        push_byte(CHR_LF);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (line_bytes.size() > 0 || s_tvalid || line_results_due.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (failures == 0)
            $display("tb_serial_command_line_parser passed");
        else
            $display("tb_serial_command_line_parser failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sclp_pkg.sv
rtl/serial_command_line_parser.sv
tb/sv/tb_serial_command_line_parser.sv
